[design/hpdd_pkg.sv]
// ----------------------------------------------------------------------------
// hpdd_pkg: shared types and constants for the heading PID drive controller
// Op codes, register indexes, sequencer states and serial unit widths.
// ----------------------------------------------------------------------------
`default_nettype none

package hpdd_pkg;

    // item op codes
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_HEADING  = 3'd1;
    localparam logic [2:0] OP_THROTTLE = 3'd2;
    localparam logic [2:0] OP_STOP     = 3'd3;
    localparam logic [2:0] OP_CLOSE    = 3'd4;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_P_GAIN     = 3'd0;
    localparam logic [2:0] REG_I_GAIN     = 3'd1;
    localparam logic [2:0] REG_D_GAIN     = 3'd2;
    localparam logic [2:0] REG_ACCEL      = 3'd3;
    localparam logic [2:0] REG_DECEL      = 3'd4;
    localparam logic [2:0] REG_TURN_LIMIT = 3'd5;

    // serial multiplier: unsigned 48 x 16, one multiplier bit per cycle
    localparam int MCAND_W   = 48;
    localparam int MPLIER_W  = 16;
    localparam int PROD_W    = 64;
    localparam int MUL_CNT_W = 4;
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = 4'(MPLIER_W - 1);

    // serial divider: restoring, one quotient bit per cycle
    localparam int DVD_W     = 58;
    localparam int DSR_W     = 23;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(DVD_W - 1);

    localparam logic [PROD_W-1:0] IPROD_LIM = 64'h0004_0000_0000_0000;
    localparam logic signed [47:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] INTEG_MIN = 48'sh8000_0000_0000;
    localparam logic signed [29:0] THR_MAX_Q16 = 30'sd8323072;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP,
        ST_DN,
        ST_EI,
        ST_P,
        ST_PD,
        ST_I,
        ST_ID,
        ST_D,
        ST_DD,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[design/hpdd_mul.sv]
// ----------------------------------------------------------------------------
// hpdd_mul: bit-serial unsigned multiplier
// Shift-and-add over the multiplier, one bit per cycle; product held after done.
// ----------------------------------------------------------------------------
`default_nettype none

module hpdd_mul import hpdd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [MCAND_W-1:0]  i_mcand,
    input  wire logic [MPLIER_W-1:0] i_mplier,
    output logic      [PROD_W-1:0]   o_prod,
    output t_unit_stat               o_stat
);

    logic [PROD_W-1:0]    r_acc;
    logic [PROD_W-1:0]    r_mcand;
    logic [MPLIER_W-1:0]  r_mplier;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= {{(PROD_W-MCAND_W){1'b0}}, i_mcand};
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[MPLIER_W-1:1]};
        end
    end

    assign o_prod      = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

[design/hpdd_div.sv]
// ----------------------------------------------------------------------------
// hpdd_div: bit-serial restoring divider
// Unsigned quotient, one bit per cycle, shifted into the dividend register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpdd_div import hpdd_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic      [DVD_W-1:0] o_quot,
    output t_unit_stat            o_stat
);

    logic [DVD_W-1:0]     r_q;
    logic [DSR_W-1:0]     r_rem;
    logic [DSR_W-1:0]     r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DSR_W:0]       rem_sh;
    logic                 ge;

    assign rem_sh = {r_rem, r_q[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? DSR_W'(rem_sh - {1'b0, r_dsr}) : rem_sh[DSR_W-1:0];
            r_q   <= {r_q[DVD_W-2:0], ge};
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

[design/heading_pid_differential_drive.sv]
// ----------------------------------------------------------------------------
// heading_pid_differential_drive: heading PID steering with slewed throttle
// Sequence: a running tick runs six multiply steps over 16 multiplier bits and
// three divide steps over 58 dividend bits, each opened by a start strobe and
// closed by a done strobe, then the output state. Stop and close go from accept
// straight to output; other items give no result and leave the input ready.
// One item at a time; a running tick blocks input until its result is loaded.
// Reset: synchronous, active low; clears config and control state; running = 1.
// ----------------------------------------------------------------------------
`default_nettype none

module heading_pid_differential_drive import hpdd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // {speed, heading_offset, elapsed_us, compass_heading} from bit 0 up
    input  wire logic [55:0] s_axis_tdata,
    // {compass_valid, op} from bit 0 up
    input  wire logic [3:0]  s_axis_tuser,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // {right_speed, left_speed} from bit 0 up
    output logic      [15:0] m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // configuration
    logic signed [15:0] r_p_gain, r_i_gain, r_d_gain;
    logic [15:0]        r_accel, r_decel;
    logic [7:0]         r_turn;

    // controller state
    logic [11:0]        r_cur_head;
    logic signed [13:0] r_tgt_head;
    logic signed [24:0] r_cur_thr;
    logic signed [7:0]  r_tgt_thr;
    logic signed [47:0] r_integ;
    logic signed [13:0] r_prev_err;
    logic               r_running;

    // sequencer and work registers
    t_state             r_state, n_state;
    logic               r_first, n_first;
    logic [19:0]        r_el;
    logic               r_is_tick;
    logic [27:0]        r_up, r_dn;
    logic               r_sign;
    logic signed [57:0] r_steer;
    logic               r_m_valid;
    logic [15:0]        r_m_data;

    // input item fields
    logic [2:0]         in_op;
    logic               in_valid;
    logic [11:0]        in_head;
    logic [19:0]        in_el;
    logic signed [12:0] in_off;
    logic signed [7:0]  in_speed;
    logic               accept;
    logic               apb_wr;

    // serial units
    logic [MCAND_W-1:0]  mul_mcand;
    logic [MPLIER_W-1:0] mul_mplier;
    logic [PROD_W-1:0]   mul_prod;
    logic                mul_start;
    t_unit_stat          mul_stat;
    logic [DVD_W-1:0]    div_dvd;
    logic [DSR_W-1:0]    div_dsr;
    logic [DVD_W-1:0]    div_q;
    logic                div_start;
    t_unit_stat          div_stat;
    logic                out_load;

    // arithmetic
    logic signed [14:0] e_raw, e_w;
    logic signed [15:0] de_w;
    logic [15:0]        e_mag, de_mag, p_mag, i_mag, d_mag;
    logic [47:0]        s_mag;
    logic [PROD_W-1:0]  i_lim;
    logic [DSR_W-1:0]   el5;
    logic signed [29:0] sl_c, sl_t, sl_n;
    logic signed [48:0] ei_s, in_sum;
    logic signed [47:0] integ_n;
    logic signed [57:0] q_s;
    logic signed [57:0] st_lim;
    logic signed [25:0] st_c;
    logic signed [26:0] mix_l, mix_r;

    function automatic logic [7:0] drive_val(input logic signed [26:0] v);
        logic signed [26:0] adj;
        logic signed [11:0] w;
        adj = v;
        // truncate toward zero to whole motor units
        if (v < 27'sd0) begin
            adj = v + 27'sd65535;
        end
        w = $signed({adj[26], adj[26:16]}) + 12'sd127;
        if (w < 12'sd0) begin
            return 8'd0;
        end else if (w > 12'sd255) begin
            return 8'hFF;
        end
        return w[7:0];
    endfunction

    assign in_op    = s_axis_tuser[2:0];
    assign in_valid = s_axis_tuser[3];
    assign in_head  = s_axis_tdata[11:0];
    assign in_el    = s_axis_tdata[31:12];
    assign in_off   = s_axis_tdata[44:32];
    assign in_speed = s_axis_tdata[52:45];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign apb_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_comb begin
        case (paddr[4:2])
            REG_P_GAIN:     prdata = {16'h0000, r_p_gain};
            REG_I_GAIN:     prdata = {16'h0000, r_i_gain};
            REG_D_GAIN:     prdata = {16'h0000, r_d_gain};
            REG_ACCEL:      prdata = {16'h0000, r_accel};
            REG_DECEL:      prdata = {16'h0000, r_decel};
            REG_TURN_LIMIT: prdata = {24'h000000, r_turn};
            default:        prdata = 32'h0000_0000;
        endcase
    end

    // heading error, wrapped once each way
    always_comb begin
        e_raw = $signed({r_tgt_head[13], r_tgt_head}) - $signed({3'b000, r_cur_head});
        e_w   = e_raw;
        if (e_w > 15'sd1800) begin
            e_w = e_w - 15'sd3600;
        end
        if (e_w < -15'sd1800) begin
            e_w = e_w + 15'sd3600;
        end
    end

    assign de_w   = $signed({e_w[14], e_w}) - $signed({{2{r_prev_err[13]}}, r_prev_err});
    assign e_mag  = e_w[14] ? 16'(-e_w) : 16'(e_w);
    assign de_mag = de_w[15] ? 16'(-de_w) : 16'(de_w);
    assign p_mag  = r_p_gain[15] ? 16'(-r_p_gain) : 16'(r_p_gain);
    assign i_mag  = r_i_gain[15] ? 16'(-r_i_gain) : 16'(r_i_gain);
    assign d_mag  = r_d_gain[15] ? 16'(-r_d_gain) : 16'(r_d_gain);
    assign s_mag  = r_integ[47] ? 48'(-r_integ) : 48'(r_integ);
    assign i_lim  = (mul_prod > IPROD_LIM) ? IPROD_LIM : mul_prod;
    assign el5    = {3'b000, r_el} + {1'b0, r_el, 2'b00};

    // throttle slew toward target
    always_comb begin
        sl_c = 30'(r_cur_thr);
        sl_t = 30'($signed({r_tgt_thr, 16'h0000}));
        sl_n = sl_c;
        if (sl_c < sl_t) begin
            if (sl_c < 30'sd0) begin
                sl_n = sl_c + $signed({2'b00, r_dn});
                if (sl_n > 30'sd0) begin
                    sl_n = 30'sd0;
                end
            end else begin
                sl_n = sl_c + $signed({2'b00, r_up});
                if (sl_n > THR_MAX_Q16) begin
                    sl_n = THR_MAX_Q16;
                end
            end
            if (sl_n > sl_t) begin
                sl_n = sl_t;
            end
        end else if (sl_c > sl_t) begin
            if (sl_c > 30'sd0) begin
                sl_n = sl_c - $signed({2'b00, r_dn});
                if (sl_n < 30'sd0) begin
                    sl_n = 30'sd0;
                end
            end else begin
                sl_n = sl_c - $signed({2'b00, r_up});
                if (sl_n < -THR_MAX_Q16) begin
                    sl_n = -THR_MAX_Q16;
                end
            end
            if (sl_n < sl_t) begin
                sl_n = sl_t;
            end
        end
    end

    // saturating integral update
    always_comb begin
        ei_s = $signed({16'h0000, mul_prod[32:0]});
        if (e_w[14]) begin
            ei_s = -ei_s;
        end
        in_sum = $signed({r_integ[47], r_integ}) + ei_s;
        if (in_sum[48] != in_sum[47]) begin
            integ_n = in_sum[48] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_n = in_sum[47:0];
        end
    end

    assign q_s = r_sign ? -$signed(div_q) : $signed(div_q);

    // steering clamp and differential mix
    always_comb begin
        st_lim = 58'($signed({2'b00, r_turn, 16'h0000}));
        if (r_steer > st_lim) begin
            st_c = st_lim[25:0];
        end else if (r_steer < -st_lim) begin
            st_c = 26'(-st_lim);
        end else begin
            st_c = r_steer[25:0];
        end
        mix_l = 27'(r_cur_thr) + 27'(st_c);
        mix_r = 27'(r_cur_thr) - 27'(st_c);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        OP_TICK:           n_state = r_running ? ST_UP : ST_IDLE;
                        OP_STOP, OP_CLOSE: n_state = ST_OUT;
                        default:           n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UP:  if (mul_stat.done) n_state = ST_DN;
            ST_DN:  if (mul_stat.done) n_state = ST_EI;
            ST_EI:  if (mul_stat.done) n_state = ST_P;
            ST_P:   if (mul_stat.done) n_state = ST_PD;
            ST_PD:  if (div_stat.done) n_state = ST_I;
            ST_I:   if (mul_stat.done) n_state = ST_ID;
            ST_ID:  if (div_stat.done) n_state = ST_D;
            ST_D:   if (mul_stat.done) n_state = ST_DD;
            ST_DD:  if (div_stat.done) n_state = ST_OUT;
            ST_OUT: if (!r_m_valid || m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        n_first = (n_state != r_state);
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        out_load      = (r_state == ST_OUT) && (!r_m_valid || m_axis_tready);
        mul_mcand     = '0;
        mul_mplier    = '0;
        mul_start     = 1'b0;
        div_dvd       = '0;
        div_dsr       = DSR_W'(5);
        div_start     = 1'b0;
        case (r_state)
            ST_UP: begin
                mul_mcand  = {28'h0, r_el};
                mul_mplier = r_accel;
                mul_start  = r_first;
            end
            ST_DN: begin
                mul_mcand  = {28'h0, r_el};
                mul_mplier = r_decel;
                mul_start  = r_first;
            end
            ST_EI: begin
                mul_mcand  = {28'h0, r_el};
                mul_mplier = e_mag;
                mul_start  = r_first;
            end
            ST_P: begin
                mul_mcand  = {32'h0, e_mag};
                mul_mplier = p_mag;
                mul_start  = r_first;
            end
            ST_I: begin
                mul_mcand  = s_mag;
                mul_mplier = i_mag;
                mul_start  = r_first;
            end
            ST_D: begin
                mul_mcand  = {32'h0, de_mag};
                mul_mplier = d_mag;
                mul_start  = r_first;
            end
            ST_PD: begin
                div_dvd   = {mul_prod[50:0], 7'b0};
                div_start = r_first;
            end
            ST_ID: begin
                div_dvd   = {i_lim[50:0], 7'b0};
                div_start = r_first;
            end
            ST_DD: begin
                div_dvd   = {mul_prod[50:0], 7'b0};
                div_dsr   = el5;
                div_start = r_first;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_gain   <= '0;
            r_i_gain   <= '0;
            r_d_gain   <= '0;
            r_accel    <= '0;
            r_decel    <= '0;
            r_turn     <= '0;
            r_cur_head <= '0;
            r_tgt_head <= '0;
            r_cur_thr  <= '0;
            r_tgt_thr  <= '0;
            r_integ    <= '0;
            r_prev_err <= '0;
            r_running  <= 1'b1;
            r_state    <= ST_IDLE;
            r_first    <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            if (apb_wr && pready) begin
                case (paddr[4:2])
                    REG_P_GAIN:     r_p_gain <= pwdata[15:0];
                    REG_I_GAIN:     r_i_gain <= pwdata[15:0];
                    REG_D_GAIN:     r_d_gain <= pwdata[15:0];
                    REG_ACCEL:      r_accel  <= pwdata[15:0];
                    REG_DECEL:      r_decel  <= pwdata[15:0];
                    REG_TURN_LIMIT: r_turn   <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (accept) begin
                case (in_op)
                    OP_TICK: begin
                        if (r_running) begin
                            r_cur_head <= in_valid ? in_head : 12'd0;
                        end
                    end
                    OP_HEADING: begin
                        r_tgt_head <= $signed({2'b00, r_cur_head}) + $signed({in_off[12], in_off});
                    end
                    OP_THROTTLE: begin
                        r_tgt_thr <= in_speed;
                    end
                    OP_STOP, OP_CLOSE: begin
                        r_tgt_head <= $signed({2'b00, r_cur_head});
                        r_cur_thr  <= '0;
                        r_tgt_thr  <= '0;
                        if (in_op == OP_CLOSE) begin
                            r_running <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == ST_EI && mul_stat.done) begin
                r_integ   <= integ_n;
                r_cur_thr <= sl_n[24:0];
            end
            if (out_load && r_is_tick) begin
                r_prev_err <= e_w[13:0];
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_el      <= (in_el == 20'd0) ? 20'd1 : in_el;
            r_is_tick <= (in_op == OP_TICK);
            // halt drives 127,127 through the normal mix
            r_steer   <= '0;
        end
        if (mul_stat.done) begin
            case (r_state)
                ST_UP: r_up <= mul_prod[35:8];
                ST_DN: r_dn <= mul_prod[35:8];
                ST_P:  r_sign <= r_p_gain[15] ^ e_w[14];
                ST_I:  r_sign <= r_i_gain[15] ^ r_integ[47];
                ST_D:  r_sign <= r_d_gain[15] ^ de_w[15];
                default: ;
            endcase
        end
        if (div_stat.done) begin
            if (r_state == ST_PD) begin
                r_steer <= q_s;
            end else begin
                r_steer <= r_steer + q_s;
            end
        end
        if (out_load) begin
            r_m_data <= {drive_val(mix_r), drive_val(mix_l)};
        end
    end

    hpdd_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_prod   (mul_prod),
        .o_stat   (mul_stat)
    );

    hpdd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_quot     (div_q),
        .o_stat     (div_stat)
    );

    assign m_axis_tdata  = r_m_data;
    assign m_axis_tvalid = r_m_valid;

    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!mul_stat.busy && !div_stat.busy))
        else $error("serial unit busy while sequencer idle");

    a_close_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser[2:0] == OP_CLOSE))
        else $error("running cleared without a close item");

    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_thr <= 25'sd8323072) && (r_cur_thr >= -25'sd8323072))
        else $error("throttle beyond full scale");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_OUT))
        else $error("result loaded outside output state");

    a_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.done |-> (r_state == ST_UP || r_state == ST_DN || r_state == ST_EI ||
                           r_state == ST_P || r_state == ST_I || r_state == ST_D))
        else $error("multiplier finished outside a multiply step");

endmodule

`default_nettype wire
